@@ sv/wrp_pkg.sv @@
// Shared types, constants and helper functions for the WAV RIFF stream parser.
`default_nettype none

package wrp_pkg;

    localparam logic [31:0] ID_RIFF_LE = 32'h4646_4952;
    localparam logic [31:0] ID_RIFF_SW = 32'h5249_4646;
    localparam logic [31:0] ID_FMT_LE  = 32'h2074_6D66;
    localparam logic [31:0] ID_FMT_SW  = 32'h666D_7420;
    localparam logic [31:0] ID_DATA_LE = 32'h6174_6164;
    localparam logic [31:0] ID_DATA_SW = 32'h6461_7461;
    localparam logic [31:0] TAG_WAVE   = 32'h4556_4157;

    localparam logic [4:0] WORD_BYTES    = 5'd4;
    localparam logic [4:0] FMT_TAG_END   = 5'd1;
    localparam logic [4:0] FMT_CHAN_END  = 5'd3;
    localparam logic [4:0] FMT_RATE_END  = 5'd7;
    localparam logic [4:0] FMT_BITS_END  = 5'd15;
    localparam logic [4:0] FMT_FIELD_SAT = 5'd16;

    localparam logic [15:0] PCM_TAG   = 16'd1;
    localparam logic [15:0] BITS_8    = 16'd8;
    localparam logic [15:0] BITS_16   = 16'd16;
    localparam logic [15:0] CHAN_MONO = 16'd1;
    localparam logic [15:0] CHAN_STEREO = 16'd2;

    localparam logic [1:0] KIND_FORMAT = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_RIFF   = 3'd1;
    localparam logic [2:0] ERR_NO_WAVE   = 3'd2;
    localparam logic [2:0] ERR_NO_FMT    = 3'd3;
    localparam logic [2:0] ERR_NOT_PCM   = 3'd4;
    localparam logic [2:0] ERR_BAD_CHAN  = 3'd5;
    localparam logic [2:0] ERR_BAD_BITS  = 3'd6;
    localparam logic [2:0] ERR_NO_DATA   = 3'd7;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [15:0] sample_word;
        logic [1:0]  channel_count;
        logic [4:0]  sample_bits;
        logic [31:0] sample_rate_hz;
        logic [2:0]  error_code;
        logic        last_of_file;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } push_t;

    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic logic [2:0] format_check(
        input logic [15:0] tag,
        input logic [15:0] chans,
        input logic [15:0] bits
    );
        if (tag != PCM_TAG)
            return ERR_NOT_PCM;
        if (chans != CHAN_MONO && chans != CHAN_STEREO)
            return ERR_BAD_CHAN;
        if (bits != BITS_8 && bits != BITS_16)
            return ERR_BAD_BITS;
        return ERR_NONE;
    endfunction

endpackage

`default_nettype wire

@@ sv/wrp_byte_if.sv @@
// Byte stream channel: one file byte and its end-of-file mark per word.
`default_nettype none

interface wrp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_file;

    modport source (output valid, output in_byte, output end_of_file, input ready);
    modport sink (input valid, input in_byte, input end_of_file, output ready);
endinterface

`default_nettype wire

@@ sv/wrp_result_if.sv @@
// Result channel: format reports, sample words and error reports.
`default_nettype none

interface wrp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [15:0] sample_word;
    logic [1:0]  channel_count;
    logic [4:0]  sample_bits;
    logic [31:0] sample_rate_hz;
    logic [2:0]  error_code;
    logic        last_of_file;

    modport source (
        output valid, output out_kind, output sample_word, output channel_count,
        output sample_bits, output sample_rate_hz, output error_code,
        output last_of_file, input ready
    );
    modport sink (
        input valid, input out_kind, input sample_word, input channel_count,
        input sample_bits, input sample_rate_hz, input error_code,
        input last_of_file, output ready
    );
endinterface

`default_nettype wire

@@ sv/wrp_front.sv @@
// Front end: accepts file bytes, walks the RIFF structure and builds result entries.
`default_nettype none

module wrp_front (
    input  wire                 clk,
    input  wire                 rst_n,
    wrp_byte_if.sink            bytes,
    input  wire                 push_ready,
    output wrp_pkg::push_t      push
);

    typedef enum logic [3:0] {
        PH_RIFF_ID    = 4'd0,
        PH_RIFF_SIZE  = 4'd1,
        PH_WAVE       = 4'd2,
        PH_CHUNK_ID   = 4'd3,
        PH_SIZE_FMT   = 4'd4,
        PH_SIZE_DATA  = 4'd5,
        PH_SIZE_OTHER = 4'd6,
        PH_FMT_BODY   = 4'd7,
        PH_SKIP_BODY  = 4'd8,
        PH_DATA       = 4'd9,
        PH_DRAIN      = 4'd10
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] id_reg, id_next;
    logic [31:0] chunk_reg, chunk_next;
    logic [31:0] riff_reg, riff_next;
    logic        swapped_reg, swapped_next;
    logic [15:0] tag_reg, tag_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic        seen_reg, seen_next;
    logic [7:0]  low_reg, low_next;

    logic        accept;
    logic        emit;
    logic [1:0]  kind;
    logic [15:0] word;
    logic [2:0]  err;
    logic        last;

    logic [7:0]  b;
    logic [31:0] id_new;
    logic [31:0] wo_new;
    logic [15:0] half_new;
    logic [31:0] riff_dec;
    logic [31:0] chunk_dec;
    logic [4:0]  cnt_inc;
    logic        word_done;
    logic        chunk_last;
    logic        check_now;
    logic        fmt_fail;
    logic        too_big;

    assign bytes.ready = push_ready;
    assign accept      = bytes.valid && push_ready;

    assign b         = bytes.in_byte;
    assign id_new    = {b, id_reg[31:8]};
    assign wo_new    = swapped_reg ? wrp_pkg::swap32(id_new) : id_new;
    assign half_new  = swapped_reg ? {id_reg[31:24], b} : {b, id_reg[31:24]};
    assign riff_dec  = (riff_reg != 32'd0) ? riff_reg - 32'd1 : riff_reg;
    assign chunk_dec = (chunk_reg != 32'd0) ? chunk_reg - 32'd1 : chunk_reg;
    assign cnt_inc   = cnt_reg + 5'd1;
    assign word_done = (cnt_inc >= wrp_pkg::WORD_BYTES);
    // chunk counter reaches zero on this byte
    assign chunk_last = (chunk_reg[31:1] == 31'd0);

    always_comb
    begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        id_next      = id_reg;
        chunk_next   = chunk_reg;
        riff_next    = riff_reg;
        swapped_next = swapped_reg;
        tag_next     = tag_reg;
        chan_next    = chan_reg;
        rate_next    = rate_reg;
        bits_next    = bits_reg;
        seen_next    = seen_reg;
        low_next     = low_reg;
        emit         = 1'b0;
        kind         = wrp_pkg::KIND_FORMAT;
        word         = 16'd0;
        err          = wrp_pkg::ERR_NONE;
        last         = 1'b0;
        check_now    = 1'b0;
        fmt_fail     = 1'b0;
        too_big      = 1'b0;

        unique case (phase_reg)
            PH_RIFF_ID:
            begin
                id_next  = id_new;
                cnt_next = cnt_inc;
                if (word_done)
                begin
                    cnt_next = 5'd0;
                    if (id_new == wrp_pkg::ID_RIFF_LE)
                    begin
                        swapped_next = 1'b0;
                        phase_next   = PH_RIFF_SIZE;
                    end
                    else if (id_new == wrp_pkg::ID_RIFF_SW)
                    begin
                        swapped_next = 1'b1;
                        phase_next   = PH_RIFF_SIZE;
                    end
                    else
                    begin
                        emit = 1'b1;
                        kind = wrp_pkg::KIND_ERROR;
                        err  = wrp_pkg::ERR_NO_RIFF;
                    end
                end
            end
            PH_RIFF_SIZE:
            begin
                id_next  = id_new;
                cnt_next = cnt_inc;
                if (word_done)
                begin
                    cnt_next   = 5'd0;
                    riff_next  = wo_new;
                    phase_next = PH_WAVE;
                end
            end
            PH_WAVE:
            begin
                riff_next = riff_dec;
                id_next   = id_new;
                cnt_next  = cnt_inc;
                if (word_done)
                begin
                    cnt_next = 5'd0;
                    if (id_new == wrp_pkg::TAG_WAVE)
                        phase_next = PH_CHUNK_ID;
                    else
                    begin
                        emit = 1'b1;
                        kind = wrp_pkg::KIND_ERROR;
                        err  = wrp_pkg::ERR_NO_WAVE;
                    end
                end
            end
            PH_CHUNK_ID:
            begin
                if (cnt_reg == 5'd0 && riff_reg == 32'd0)
                begin
                    // walk ran out of RIFF body
                    emit = 1'b1;
                    kind = wrp_pkg::KIND_ERROR;
                    err  = seen_reg ? wrp_pkg::ERR_NO_DATA : wrp_pkg::ERR_NO_FMT;
                end
                else
                begin
                    riff_next = riff_dec;
                    id_next   = id_new;
                    cnt_next  = cnt_inc;
                    if (word_done)
                    begin
                        cnt_next = 5'd0;
                        if (id_new == (swapped_reg ? wrp_pkg::ID_FMT_SW : wrp_pkg::ID_FMT_LE)
                            && !seen_reg)
                            phase_next = PH_SIZE_FMT;
                        else if (id_new ==
                                 (swapped_reg ? wrp_pkg::ID_DATA_SW : wrp_pkg::ID_DATA_LE))
                            phase_next = PH_SIZE_DATA;
                        else
                            phase_next = PH_SIZE_OTHER;
                    end
                end
            end
            PH_SIZE_FMT, PH_SIZE_DATA, PH_SIZE_OTHER:
            begin
                riff_next = riff_dec;
                id_next   = id_new;
                cnt_next  = cnt_inc;
                if (word_done)
                begin
                    cnt_next = 5'd0;
                    if (phase_reg == PH_SIZE_OTHER)
                    begin
                        // size beyond the body left after this byte
                        too_big = wo_new[31] ||
                                  ((riff_reg == 32'd0) ? (wo_new != 32'd0)
                                                       : (wo_new >= riff_reg));
                        if (too_big)
                        begin
                            emit = 1'b1;
                            kind = wrp_pkg::KIND_ERROR;
                            err  = seen_reg ? wrp_pkg::ERR_NO_DATA : wrp_pkg::ERR_NO_FMT;
                        end
                        else if (wo_new == 32'd0)
                            phase_next = PH_CHUNK_ID;
                        else
                        begin
                            chunk_next = wo_new;
                            phase_next = PH_SKIP_BODY;
                        end
                    end
                    else if (phase_reg == PH_SIZE_FMT)
                    begin
                        tag_next   = 16'd0;
                        chan_next  = 16'd0;
                        rate_next  = 32'd0;
                        bits_next  = 16'd0;
                        chunk_next = wo_new;
                        if (wo_new == 32'd0)
                        begin
                            emit = 1'b1;
                            kind = wrp_pkg::KIND_ERROR;
                            err  = wrp_pkg::format_check(16'd0, 16'd0, 16'd0);
                        end
                        else
                            phase_next = PH_FMT_BODY;
                    end
                    else if (!seen_reg)
                    begin
                        emit = 1'b1;
                        kind = wrp_pkg::KIND_ERROR;
                        err  = wrp_pkg::ERR_NO_FMT;
                    end
                    else
                    begin
                        chunk_next = wo_new;
                        if ((bits_reg == wrp_pkg::BITS_16) ? (wo_new[31:1] == 31'd0)
                                                           : (wo_new == 32'd0))
                            phase_next = PH_DRAIN;
                        else
                            phase_next = PH_DATA;
                    end
                end
            end
            PH_FMT_BODY:
            begin
                riff_next  = riff_dec;
                chunk_next = chunk_dec;
                id_next    = id_new;
                if (cnt_reg < wrp_pkg::FMT_FIELD_SAT)
                    cnt_next = cnt_inc;
                if (cnt_reg == wrp_pkg::FMT_TAG_END)
                    tag_next = half_new;
                else if (cnt_reg == wrp_pkg::FMT_CHAN_END)
                    chan_next = half_new;
                else if (cnt_reg == wrp_pkg::FMT_RATE_END)
                    rate_next = wo_new;
                else if (cnt_reg == wrp_pkg::FMT_BITS_END)
                    bits_next = half_new;
                check_now = (cnt_reg == wrp_pkg::FMT_BITS_END) ||
                            (chunk_last && cnt_reg < wrp_pkg::FMT_BITS_END);
                if (check_now)
                begin
                    emit = 1'b1;
                    err  = wrp_pkg::format_check(tag_next, chan_next, bits_next);
                    if (err != wrp_pkg::ERR_NONE)
                    begin
                        fmt_fail = 1'b1;
                        kind     = wrp_pkg::KIND_ERROR;
                    end
                    else
                    begin
                        seen_next = 1'b1;
                        kind      = wrp_pkg::KIND_FORMAT;
                    end
                end
                if (!fmt_fail && chunk_last)
                begin
                    cnt_next   = 5'd0;
                    phase_next = PH_CHUNK_ID;
                end
            end
            PH_SKIP_BODY:
            begin
                riff_next  = riff_dec;
                chunk_next = chunk_dec;
                if (chunk_last)
                begin
                    cnt_next   = 5'd0;
                    phase_next = PH_CHUNK_ID;
                end
            end
            PH_DATA:
            begin
                chunk_next = chunk_dec;
                if (bits_reg != wrp_pkg::BITS_16)
                begin
                    emit = 1'b1;
                    kind = wrp_pkg::KIND_SAMPLE;
                    word = {8'd0, b};
                    if (chunk_last)
                    begin
                        last       = 1'b1;
                        phase_next = PH_DRAIN;
                    end
                end
                else if (cnt_reg == 5'd0)
                begin
                    low_next = b;
                    cnt_next = 5'd1;
                end
                else
                begin
                    cnt_next = 5'd0;
                    emit     = 1'b1;
                    kind     = wrp_pkg::KIND_SAMPLE;
                    word     = swapped_reg ? {low_reg, b} : {b, low_reg};
                    // an odd trailing byte is dropped
                    if (chunk_reg < 32'd3)
                    begin
                        last       = 1'b1;
                        phase_next = PH_DRAIN;
                    end
                end
            end
            default:
            begin
                // drain: hold everything until end of file
            end
        endcase

        if (emit && kind == wrp_pkg::KIND_ERROR)
        begin
            last       = 1'b1;
            phase_next = PH_DRAIN;
        end

        if (bytes.end_of_file)
        begin
            if (emit && kind == wrp_pkg::KIND_FORMAT)
            begin
                kind = wrp_pkg::KIND_ERROR;
                err  = wrp_pkg::ERR_NO_DATA;
            end
            else if (!emit)
            begin
                unique case (phase_next) inside
                    PH_RIFF_ID, PH_RIFF_SIZE:
                    begin
                        emit = 1'b1;
                        err  = wrp_pkg::ERR_NO_RIFF;
                    end
                    PH_WAVE:
                    begin
                        emit = 1'b1;
                        err  = wrp_pkg::ERR_NO_WAVE;
                    end
                    PH_DATA:
                    begin
                        emit = 1'b1;
                        err  = wrp_pkg::ERR_NO_DATA;
                    end
                    PH_CHUNK_ID, PH_SIZE_FMT, PH_SIZE_DATA, PH_SIZE_OTHER,
                    PH_FMT_BODY, PH_SKIP_BODY:
                    begin
                        emit = 1'b1;
                        err  = seen_next ? wrp_pkg::ERR_NO_DATA : wrp_pkg::ERR_NO_FMT;
                    end
                    default:
                    begin
                        emit = 1'b0;
                    end
                endcase
                kind = wrp_pkg::KIND_ERROR;
            end
            if (emit)
                last = 1'b1;
        end
    end

    always_comb
    begin
        push.valid                    = accept && emit;
        push.data.out_kind            = kind;
        push.data.sample_word         = (kind == wrp_pkg::KIND_SAMPLE) ? word : 16'd0;
        push.data.channel_count       = seen_next ? chan_next[1:0] : 2'd0;
        push.data.sample_bits         = seen_next ? bits_next[4:0] : 5'd0;
        push.data.sample_rate_hz      = seen_next ? rate_next : 32'd0;
        push.data.error_code          = (kind == wrp_pkg::KIND_ERROR) ? err
                                                                      : wrp_pkg::ERR_NONE;
        push.data.last_of_file        = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_RIFF_ID;
            cnt_reg     <= 5'd0;
            id_reg      <= 32'd0;
            chunk_reg   <= 32'd0;
            riff_reg    <= 32'd0;
            swapped_reg <= 1'b0;
            tag_reg     <= 16'd0;
            chan_reg    <= 16'd0;
            rate_reg    <= 32'd0;
            bits_reg    <= 16'd0;
            seen_reg    <= 1'b0;
            low_reg     <= 8'd0;
        end
        else if (accept)
        begin
            if (bytes.end_of_file)
            begin
                // start over for the next file
                phase_reg   <= PH_RIFF_ID;
                cnt_reg     <= 5'd0;
                id_reg      <= 32'd0;
                chunk_reg   <= 32'd0;
                riff_reg    <= 32'd0;
                swapped_reg <= 1'b0;
                tag_reg     <= 16'd0;
                chan_reg    <= 16'd0;
                rate_reg    <= 32'd0;
                bits_reg    <= 16'd0;
                seen_reg    <= 1'b0;
                low_reg     <= 8'd0;
            end
            else
            begin
                phase_reg   <= phase_next;
                cnt_reg     <= cnt_next;
                id_reg      <= id_next;
                chunk_reg   <= chunk_next;
                riff_reg    <= riff_next;
                swapped_reg <= swapped_next;
                tag_reg     <= tag_next;
                chan_reg    <= chan_next;
                rate_reg    <= rate_next;
                bits_reg    <= bits_next;
                seen_reg    <= seen_next;
                low_reg     <= low_next;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/wrp_queue.sv @@
// Back end: two-entry result queue that drives the result channel.
`default_nettype none

module wrp_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wrp_pkg::push_t      push,
    output logic                push_ready,
    wrp_result_if.source        results
);

    wrp_pkg::result_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       pop;
    logic       put;
    wrp_pkg::result_t head;

    assign push_ready = (count_reg != 2'd2);
    assign put        = push.valid && push_ready;
    assign pop        = results.valid && results.ready;
    assign head       = slot_reg[rd_ptr_reg];

    assign results.valid          = (count_reg != 2'd0);
    assign results.out_kind       = head.out_kind;
    assign results.sample_word    = head.sample_word;
    assign results.channel_count  = head.channel_count;
    assign results.sample_bits    = head.sample_bits;
    assign results.sample_rate_hz = head.sample_rate_hz;
    assign results.error_code     = head.error_code;
    assign results.last_of_file   = head.last_of_file;

    always_comb
    begin
        count_next = count_reg;
        if (put && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !put)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (put)
            slot_reg[wr_ptr_reg] <= push.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (put)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/wav_riff_stream_parser.sv @@
// WAV RIFF stream parser: bytes in, format reports, samples and errors out.
// Feed the file on the bytes channel one byte per word, with end_of_file set
// on the last byte. The block walks the RIFF header, the WAVE tag and the
// sub-chunks, validates the fmt chunk and emits data samples on the results
// channel: a format report, then one word per 8-bit byte or 16-bit pair, or
// an error report with last_of_file set. Each accepted byte gives at most one
// result word.
// Throughput is one byte per cycle while the queue is not full; parse state
// is updated in the cycle a byte is accepted. Results wait in a two-entry
// queue between the parser and the result port, written as a byte is taken.
// When the receiver stalls, the queue absorbs up to two results; bytes are
// refused only while the queue is full. After end_of_file the parser returns
// to its start state for the next file.
// Reset clears the parse state and empties the queue; no words are
// presented until new bytes arrive.
`default_nettype none

module wav_riff_stream_parser (
    input  wire             clk,
    input  wire             rst_n,
    wrp_byte_if.sink        bytes,
    wrp_result_if.source    results
);

    wrp_pkg::push_t push;
    logic           push_ready;

    wrp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .push_ready (push_ready),
        .push       (push)
    );

    wrp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .results    (results)
    );

endmodule

`default_nettype wire

@@ tb/wav_riff_stream_parser_test.sv @@
// Self-checking testbench for the WAV RIFF stream parser with its own parse model.
`default_nettype none

module wav_riff_stream_parser_test;
    import wrp_pkg::*;

    localparam int RANDOM_BYTES   = 1450;
    localparam int QUIET_FROM     = 1200;
    localparam int WATCHDOG_LIMIT = 400;
    localparam int SETTLE_CYCLES  = 8;

    typedef enum logic [3:0] {
        ST_TAG_RIFF,
        ST_RIFF_LEN,
        ST_WAVE_TAG,
        ST_CHUNK_HDR,
        ST_FMT_LEN,
        ST_DATA_LEN,
        ST_SKIP_LEN,
        ST_FMT_FIELDS,
        ST_SKIP,
        ST_SAMPLES,
        ST_WAIT_EOF
    } walk_state_t;

    typedef struct packed {
        logic [7:0] b;
        logic       eof;
        logic [2:0] typed_err;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       feed_valid = 1'b0;
    logic [7:0] feed_byte = 8'h00;
    logic       feed_eof = 1'b0;
    logic       take_ready = 1'b0;

    wrp_byte_if   bytes_ch ();
    wrp_result_if results_ch ();

    assign bytes_ch.valid       = feed_valid;
    assign bytes_ch.in_byte     = feed_byte;
    assign bytes_ch.end_of_file = feed_eof;
    assign results_ch.ready     = take_ready;

    wav_riff_stream_parser i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes_ch),
        .results (results_ch)
    );

    always #10 clk = ~clk;

    // Parse model state
    walk_state_t st;
    logic [31:0] hdr_count;
    logic [31:0] window;
    logic [31:0] chunk_left;
    logic [31:0] riff_left;
    logic        be_order;
    logic [15:0] fmt_tag;
    logic [15:0] fmt_chans;
    logic [31:0] fmt_rate;
    logic [15:0] fmt_bits;
    logic        fmt_locked;
    logic [7:0]  held_low;

    result_t     due_reports [$];
    int          fault_count = 0;
    bit          no_idle = 1'b0;

    logic [7:0]  file_q [$];
    logic        build_be;

    // Bad id, lone byte, minimal swapped file that runs out, missing WAVE tag
    plan_row_t walk_plan [27] = '{
        '{8'h52, 1'b0, ERR_NONE}, '{8'h49, 1'b0, ERR_NONE}, '{8'h46, 1'b0, ERR_NONE},
        '{8'h58, 1'b0, ERR_NO_RIFF}, '{8'h00, 1'b1, ERR_NONE},
        '{8'hFF, 1'b1, ERR_NO_RIFF},
        '{8'h46, 1'b0, ERR_NONE}, '{8'h46, 1'b0, ERR_NONE}, '{8'h49, 1'b0, ERR_NONE},
        '{8'h52, 1'b0, ERR_NONE}, '{8'h00, 1'b0, ERR_NONE}, '{8'h00, 1'b0, ERR_NONE},
        '{8'h00, 1'b0, ERR_NONE}, '{8'h04, 1'b0, ERR_NONE}, '{8'h57, 1'b0, ERR_NONE},
        '{8'h41, 1'b0, ERR_NONE}, '{8'h56, 1'b0, ERR_NONE}, '{8'h45, 1'b0, ERR_NONE},
        '{8'h00, 1'b1, ERR_NO_FMT},
        '{8'h52, 1'b0, ERR_NONE}, '{8'h49, 1'b0, ERR_NONE}, '{8'h46, 1'b0, ERR_NONE},
        '{8'h46, 1'b0, ERR_NONE}, '{8'hFF, 1'b0, ERR_NONE}, '{8'hFF, 1'b0, ERR_NONE},
        '{8'hFF, 1'b0, ERR_NONE}, '{8'hFF, 1'b1, ERR_NO_WAVE}
    };

    function automatic void clear_parser();
        st = ST_TAG_RIFF;
        hdr_count = '0;
        window = '0;
        chunk_left = '0;
        riff_left = '0;
        be_order = 1'b0;
        fmt_tag = '0;
        fmt_chans = '0;
        fmt_rate = '0;
        fmt_bits = '0;
        fmt_locked = 1'b0;
        held_low = '0;
    endfunction

    function automatic logic [31:0] ordered32(input logic [31:0] v);
        return be_order ? {v[7:0], v[15:8], v[23:16], v[31:24]} : v;
    endfunction

    function automatic logic [15:0] ordered16();
        logic [15:0] v;
        v = window[31:16];
        return be_order ? {v[7:0], v[15:8]} : v;
    endfunction

    function automatic logic [2:0] fmt_verdict();
        if (fmt_tag != PCM_TAG)
            return ERR_NOT_PCM;
        if (fmt_chans != CHAN_MONO && fmt_chans != CHAN_STEREO)
            return ERR_BAD_CHAN;
        if (fmt_bits != BITS_8 && fmt_bits != BITS_16)
            return ERR_BAD_BITS;
        return ERR_NONE;
    endfunction

    function automatic logic [2:0] walk_fault();
        return fmt_locked ? ERR_NO_DATA : ERR_NO_FMT;
    endfunction

    // Advance the parse model by one byte; got says whether a word is due
    function automatic void parse_byte(input logic [7:0] b, input logic eof,
                                       output bit got, output result_t r);
        bit          emit;
        logic [1:0]  kind;
        logic [15:0] word;
        logic [2:0]  err;
        logic        last;
        logic [31:0] size;
        logic [31:0] off;
        emit = 1'b0;
        kind = KIND_FORMAT;
        word = '0;
        err = ERR_NONE;
        last = 1'b0;
        case (st)
            ST_TAG_RIFF:
            begin
                window = {b, window[31:8]};
                hdr_count++;
                if (hdr_count >= 4)
                begin
                    hdr_count = '0;
                    if (window == ID_RIFF_LE)
                    begin
                        be_order = 1'b0;
                        st = ST_RIFF_LEN;
                    end
                    else if (window == ID_RIFF_SW)
                    begin
                        be_order = 1'b1;
                        st = ST_RIFF_LEN;
                    end
                    else
                    begin
                        emit = 1'b1;
                        kind = KIND_ERROR;
                        err = ERR_NO_RIFF;
                    end
                end
            end
            ST_RIFF_LEN:
            begin
                window = {b, window[31:8]};
                hdr_count++;
                if (hdr_count >= 4)
                begin
                    hdr_count = '0;
                    riff_left = ordered32(window);
                    st = ST_WAVE_TAG;
                end
            end
            ST_WAVE_TAG:
            begin
                if (riff_left != 0)
                    riff_left--;
                window = {b, window[31:8]};
                hdr_count++;
                if (hdr_count >= 4)
                begin
                    hdr_count = '0;
                    if (window == TAG_WAVE)
                        st = ST_CHUNK_HDR;
                    else
                    begin
                        emit = 1'b1;
                        kind = KIND_ERROR;
                        err = ERR_NO_WAVE;
                    end
                end
            end
            ST_CHUNK_HDR:
            begin
                if (hdr_count == 0 && riff_left == 0)
                begin
                    emit = 1'b1;
                    kind = KIND_ERROR;
                    err = walk_fault();
                end
                else
                begin
                    if (riff_left != 0)
                        riff_left--;
                    window = {b, window[31:8]};
                    hdr_count++;
                    if (hdr_count >= 4)
                    begin
                        hdr_count = '0;
                        if (window == (be_order ? ID_FMT_SW : ID_FMT_LE) && !fmt_locked)
                            st = ST_FMT_LEN;
                        else if (window == (be_order ? ID_DATA_SW : ID_DATA_LE))
                            st = ST_DATA_LEN;
                        else
                            st = ST_SKIP_LEN;
                    end
                end
            end
            ST_FMT_LEN, ST_DATA_LEN, ST_SKIP_LEN:
            begin
                if (riff_left != 0)
                    riff_left--;
                window = {b, window[31:8]};
                hdr_count++;
                if (hdr_count >= 4)
                begin
                    hdr_count = '0;
                    size = ordered32(window);
                    if (st == ST_SKIP_LEN)
                    begin
                        if (size[31] || size > riff_left)
                        begin
                            emit = 1'b1;
                            kind = KIND_ERROR;
                            err = walk_fault();
                        end
                        else if (size == 0)
                            st = ST_CHUNK_HDR;
                        else
                        begin
                            chunk_left = size;
                            st = ST_SKIP;
                        end
                    end
                    else if (st == ST_FMT_LEN)
                    begin
                        fmt_tag = '0;
                        fmt_chans = '0;
                        fmt_rate = '0;
                        fmt_bits = '0;
                        chunk_left = size;
                        if (size == 0)
                        begin
                            emit = 1'b1;
                            kind = KIND_ERROR;
                            err = fmt_verdict();
                        end
                        else
                            st = ST_FMT_FIELDS;
                    end
                    else if (!fmt_locked)
                    begin
                        emit = 1'b1;
                        kind = KIND_ERROR;
                        err = ERR_NO_FMT;
                    end
                    else
                    begin
                        chunk_left = size;
                        if (size < ((fmt_bits == BITS_16) ? 2 : 1))
                            st = ST_WAIT_EOF;
                        else
                            st = ST_SAMPLES;
                    end
                end
            end
            ST_FMT_FIELDS:
            begin
                if (riff_left != 0)
                    riff_left--;
                if (chunk_left != 0)
                    chunk_left--;
                window = {b, window[31:8]};
                off = hdr_count;
                if (hdr_count < 16)
                    hdr_count++;
                if (off == 1)
                    fmt_tag = ordered16();
                else if (off == 3)
                    fmt_chans = ordered16();
                else if (off == 7)
                    fmt_rate = ordered32(window);
                else if (off == 15)
                    fmt_bits = ordered16();
                if (off == 15 || (chunk_left == 0 && off < 15))
                begin
                    emit = 1'b1;
                    err = fmt_verdict();
                    if (err != ERR_NONE)
                        kind = KIND_ERROR;
                    else
                    begin
                        fmt_locked = 1'b1;
                        kind = KIND_FORMAT;
                    end
                end
                // a failed format stays put; the error path below ends the walk
                if (!(emit && kind == KIND_ERROR) && chunk_left == 0)
                begin
                    hdr_count = '0;
                    st = ST_CHUNK_HDR;
                end
            end
            ST_SKIP:
            begin
                if (riff_left != 0)
                    riff_left--;
                if (chunk_left != 0)
                    chunk_left--;
                if (chunk_left == 0)
                begin
                    hdr_count = '0;
                    st = ST_CHUNK_HDR;
                end
            end
            ST_SAMPLES:
            begin
                if (chunk_left != 0)
                    chunk_left--;
                if (fmt_bits != BITS_16)
                begin
                    emit = 1'b1;
                    kind = KIND_SAMPLE;
                    word = {8'h00, b};
                    if (chunk_left == 0)
                    begin
                        last = 1'b1;
                        st = ST_WAIT_EOF;
                    end
                end
                else if (hdr_count == 0)
                begin
                    held_low = b;
                    hdr_count = 32'd1;
                end
                else
                begin
                    hdr_count = '0;
                    emit = 1'b1;
                    kind = KIND_SAMPLE;
                    word = be_order ? {held_low, b} : {b, held_low};
                    if (chunk_left < 2)
                    begin
                        last = 1'b1;
                        st = ST_WAIT_EOF;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (emit && kind == KIND_ERROR)
        begin
            last = 1'b1;
            st = ST_WAIT_EOF;
        end

        if (eof)
        begin
            if (emit && kind == KIND_FORMAT)
            begin
                kind = KIND_ERROR;
                err = ERR_NO_DATA;
            end
            else if (!emit && st != ST_WAIT_EOF && st <= ST_SAMPLES)
            begin
                emit = 1'b1;
                kind = KIND_ERROR;
                if (st == ST_TAG_RIFF || st == ST_RIFF_LEN)
                    err = ERR_NO_RIFF;
                else if (st == ST_WAVE_TAG)
                    err = ERR_NO_WAVE;
                else if (st == ST_SAMPLES)
                    err = ERR_NO_DATA;
                else
                    err = walk_fault();
            end
            if (emit)
                last = 1'b1;
        end

        got = emit;
        r.out_kind = kind;
        r.sample_word = (kind == KIND_SAMPLE) ? word : 16'h0000;
        r.channel_count = fmt_locked ? fmt_chans[1:0] : 2'd0;
        r.sample_bits = fmt_locked ? fmt_bits[4:0] : 5'd0;
        r.sample_rate_hz = fmt_locked ? fmt_rate : 32'd0;
        r.error_code = (kind == KIND_ERROR) ? err : ERR_NONE;
        r.last_of_file = last;

        if (eof)
            clear_parser();
    endfunction

    // Stimulus file builders
    function automatic void put_byte(input logic [7:0] v);
        file_q.push_back(v);
    endfunction

    // literal: bytes go out in file order regardless of the chosen byte order
    function automatic void put_u32(input logic [31:0] v, input bit literal);
        if (build_be && !literal)
        begin
            put_byte(v[31:24]);
            put_byte(v[23:16]);
            put_byte(v[15:8]);
            put_byte(v[7:0]);
        end
        else
        begin
            put_byte(v[7:0]);
            put_byte(v[15:8]);
            put_byte(v[23:16]);
            put_byte(v[31:24]);
        end
    endfunction

    function automatic void put_u16(input logic [15:0] v);
        if (build_be)
        begin
            put_byte(v[15:8]);
            put_byte(v[7:0]);
        end
        else
        begin
            put_byte(v[7:0]);
            put_byte(v[15:8]);
        end
    endfunction

    function automatic void put_skip_chunk(input bit bad_size);
        logic [31:0] size;
        if (bad_size)
            size = $urandom_range(0, 1) ? ($urandom | 32'h8000_0000)
                                        : 32'd5000 + $urandom_range(0, 99);
        else
            size = $urandom_range(0, 6);
        put_u32($urandom, 1'b1);
        put_u32(size, 1'b0);
        if (!bad_size)
            repeat (size) put_byte(8'($urandom));
    endfunction

    function automatic void put_data_chunk();
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 80) : $urandom_range(0, 24);
        put_u32(ID_DATA_LE, 1'b0);
        put_u32(len, 1'b0);
        repeat (len) put_byte(8'($urandom));
    endfunction

    function automatic void put_fmt_fields(input bit plausible);
        logic [15:0] chans;
        logic [15:0] bits;
        case ($urandom_range(0, 11))
            0: chans = 16'($urandom);
            1: chans = 16'($urandom_range(0, 3));
            default: chans = 16'($urandom_range(1, 2));
        endcase
        case ($urandom_range(0, 11))
            0: bits = 16'($urandom);
            1: bits = 16'($urandom_range(0, 24));
            default: bits = $urandom_range(0, 1) ? BITS_16 : BITS_8;
        endcase
        put_u16((!plausible || $urandom_range(0, 15) == 0) ? 16'($urandom) : PCM_TAG);
        put_u16(chans);
        put_u32($urandom, 1'b0);
        put_u32($urandom, 1'b0);
        put_u16(16'($urandom));
        put_u16(bits);
    endfunction

    // Build one file: mostly well-formed with random content, some broken or noise
    function automatic void build_file();
        int          pick;
        int          fmt_len;
        int          mark;
        int          cut;
        logic [31:0] riff_len;
        logic [7:0]  body [$];
        file_q.delete();
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            repeat ($urandom_range(1, 12)) put_byte(8'($urandom));
            return;
        end
        build_be = 1'($urandom_range(0, 1));
        put_u32((pick < 14) ? $urandom : TAG_WAVE, 1'b1);
        if (pick < 24 || $urandom_range(0, 3) == 0)
            put_skip_chunk(pick >= 18 && pick < 24);
        if (pick >= 24 && pick < 28)
            put_data_chunk();

        fmt_len = 16;
        case ($urandom_range(0, 11))
            0: fmt_len = $urandom_range(0, 15);
            1: fmt_len = $urandom_range(17, 22);
            default: fmt_len = 16;
        endcase
        put_u32(ID_FMT_LE, 1'b0);
        put_u32(fmt_len, 1'b0);
        mark = file_q.size();
        put_fmt_fields(1'b1);
        while (file_q.size() > mark + fmt_len)
            void'(file_q.pop_back());
        repeat ((fmt_len > 16) ? fmt_len - 16 : 0) put_byte(8'($urandom));

        // a second fmt is walked over like any unknown chunk
        if ($urandom_range(0, 7) == 0)
        begin
            put_u32(ID_FMT_LE, 1'b0);
            put_u32(32'd16, 1'b0);
            put_fmt_fields(1'b0);
        end
        if ($urandom_range(0, 3) == 0)
            put_skip_chunk(1'b0);
        put_data_chunk();
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) put_byte(8'($urandom));

        riff_len = file_q.size();
        case ($urandom_range(0, 9))
            0: riff_len = $urandom_range(0, file_q.size());
            1: riff_len = $urandom;
            default: riff_len = file_q.size();
        endcase

        body = file_q;
        file_q.delete();
        put_u32((pick >= 14 && pick < 18) ? $urandom : ID_RIFF_LE, 1'b0);
        put_u32(riff_len, 1'b0);
        foreach (body[i])
            put_byte(body[i]);

        if ($urandom_range(0, 9) == 0)
        begin
            cut = $urandom_range(1, file_q.size());
            while (file_q.size() > cut)
                void'(file_q.pop_back());
        end
    endfunction

    // Offer one word on the byte channel and book the results it causes
    task automatic feed(input logic [7:0] b, input logic eof, input logic [2:0] typed_err);
        bit      got;
        result_t r;
        if (!no_idle && $urandom_range(0, 9) == 0)
        begin
            feed_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        feed_valid <= 1'b1;
        feed_byte <= b;
        feed_eof <= eof;
        @(posedge clk);
        while (!bytes_ch.ready)
            @(posedge clk);
        parse_byte(b, eof, got, r);
        if (typed_err != ERR_NONE)
            due_reports.push_back('{out_kind: KIND_ERROR, sample_word: 16'h0000,
                                    channel_count: 2'd0, sample_bits: 5'd0,
                                    sample_rate_hz: 32'd0, error_code: typed_err,
                                    last_of_file: 1'b1});
        else if (got)
            due_reports.push_back(r);
    endtask

    function automatic void note_field(input string name, input logic [31:0] want,
                                       input logic [31:0] seen);
        if (want !== seen)
        begin
            fault_count++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, seen);
        end
    endfunction

    // Result side: random stall bursts, and check every accepted word
    int stall_left = 0;

    always @(posedge clk)
    begin
        result_t want;
        result_t seen;
        if (results_ch.valid && results_ch.ready)
        begin
            seen.out_kind = results_ch.out_kind;
            seen.sample_word = results_ch.sample_word;
            seen.channel_count = results_ch.channel_count;
            seen.sample_bits = results_ch.sample_bits;
            seen.sample_rate_hz = results_ch.sample_rate_hz;
            seen.error_code = results_ch.error_code;
            seen.last_of_file = results_ch.last_of_file;
            if (due_reports.size() == 0)
            begin
                fault_count++;
                $display("%0t: expected no result, got %h", $time, seen);
            end
            else
            begin
                want = due_reports.pop_front();
                note_field("out_kind", 32'(want.out_kind), 32'(seen.out_kind));
                note_field("sample_word", 32'(want.sample_word), 32'(seen.sample_word));
                note_field("channel_count", 32'(want.channel_count),
                           32'(seen.channel_count));
                note_field("sample_bits", 32'(want.sample_bits), 32'(seen.sample_bits));
                note_field("sample_rate_hz", want.sample_rate_hz, seen.sample_rate_hz);
                note_field("error_code", 32'(want.error_code), 32'(seen.error_code));
                note_field("last_of_file", 32'(want.last_of_file),
                           32'(seen.last_of_file));
            end
        end

        if (!rst_n)
            take_ready <= 1'b0;
        else if (stall_left != 0)
        begin
            stall_left--;
            take_ready <= 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 11) == 0)
        begin
            stall_left = $urandom_range(0, 16);
            take_ready <= 1'b0;
        end
        else
            take_ready <= 1'b1;
    end

    // Watchdog: too long with no word moving on either side
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((bytes_ch.valid && bytes_ch.ready) || (results_ch.valid && results_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("wav_riff_stream_parser: mismatch");
            $finish;
        end
    end

    initial
    begin
        int sent;
        sent = 0;
        clear_parser();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (walk_plan[i])
            feed(walk_plan[i].b, walk_plan[i].eof, walk_plan[i].typed_err);

        while (sent < RANDOM_BYTES)
        begin
            no_idle = (sent >= QUIET_FROM);
            build_file();
            for (int i = 0; i < file_q.size(); i++)
                feed(file_q[i], i == file_q.size() - 1, ERR_NONE);
            sent += file_q.size();
        end
        feed_valid <= 1'b0;

        while (due_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("wav_riff_stream_parser: match");
        else
            $display("wav_riff_stream_parser: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
